// File: hw/rtl/speculative_fetch_stage_assert.svh
// Assertion macros for the speculative fetch stage.
// Depends on nothing; included by the top level of the block.
`ifndef SPECULATIVE_FETCH_STAGE_ASSERT_SVH
`define SPECULATIVE_FETCH_STAGE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SFS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: condition must never hold");

`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: expected outcome on the next cycle");

`else

`define SFS_ASSERT_NEVER(label, clk, rst_n, expr)

`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/sfs_pkg.sv
// Package of the speculative fetch stage: transaction types and fixed constants.
// Depends on nothing; used by the front, back and top-level modules and by the testbench.
package sfs_pkg;

    localparam int PC_OUT_W   = 10;
    localparam int ADDR_W     = 16;
    localparam int TAG_OUT_W  = 16;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALT_OPCODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_MASK = 2'd1;

    localparam int OPC_HI  = 31;
    localparam int OPC_LO  = 28;
    localparam int DEST_HI = 27;
    localparam int DEST_LO = 24;
    localparam int IMM_HI  = 15;

    typedef logic [PC_OUT_W-1:0] pc_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [3:0] nibble_t;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] instr_word;
        pc_t               btb_target;
        logic              queue_full;
        logic              mispredicted;
        pc_t               restart_pc;
    } fetch_item_t;

    typedef struct packed {
        nibble_t               opcode;
        nibble_t               dest_reg;
        nibble_t               src_a;
        nibble_t               src_b;
        logic [15:0]           immediate;
        logic [TAG_OUT_W-1:0]  tag;
        logic                  speculative;
        pc_t                   predicted_target;
        pc_t                   fallthrough_pc;
        pc_t                   next_pc;
    } fetch_result_t;

    typedef struct packed {
        logic        kind;
        logic        queue_full;
        logic        mispredicted;
        logic        is_branch;
        logic        is_halt;
        nibble_t     opcode;
        nibble_t     dest_reg;
        nibble_t     src_a;
        nibble_t     src_b;
        logic [15:0] immediate;
        pc_t         btb_target;
        addr_t       target_pc;
        addr_t       restart_pc;
    } fetch_entry_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage

// File: hw/rtl/sfs_queue.sv
// Small first-in first-out queue of flip-flops with a count of entries held.
// Depends on nothing; used between the front and back parts and at the result side.
module sfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/sfs_front.sv
// Front part: holds the configuration, decodes each transaction and reduces its addresses.
// Depends on sfs_pkg; feeds the middle queue of the block.
module sfs_front #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sfs_pkg::fetch_item_t in_item,
    input  logic                 cfg_we,
    input  sfs_pkg::cfg_write_t  cfg_wr,
    output logic                 out_valid,
    output sfs_pkg::fetch_entry_t out_entry
);

    import sfs_pkg::*;

    // Addresses are reduced with a reciprocal multiply that is exact for 10-bit values.
    localparam int MOD_M   = (MEM_DEPTH < 1024) ? MEM_DEPTH : 1024;
    localparam int MOD_W   = $clog2(MOD_M);
    localparam int SHIFT   = PC_OUT_W + MOD_W;
    localparam int RECIP_W = PC_OUT_W + 2;
    localparam int PROD_W  = PC_OUT_W + RECIP_W;
    localparam int MUL_W   = 2 * PC_OUT_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + MOD_M - 1) / MOD_M);

    logic [3:0]   halt_opcode_reg;
    logic [15:0]  branch_mask_reg;

    fetch_item_t  s1_item_reg;
    pc_t          s1_tgt_q_reg;
    pc_t          s1_rst_q_reg;
    logic         s1_branch_reg;
    logic         s1_halt_reg;
    logic         s1_valid_reg;

    fetch_entry_t s2_entry_reg, s2_entry_next;
    logic         s2_valid_reg;

    logic [PROD_W-1:0] tgt_prod;
    logic [PROD_W-1:0] rst_prod;
    logic [MUL_W-1:0]  tgt_qm;
    logic [MUL_W-1:0]  rst_qm;
    logic [MUL_W-1:0]  tgt_rem;
    logic [MUL_W-1:0]  rst_rem;
    nibble_t           opc;

    assign opc      = in_item.instr_word[OPC_HI:OPC_LO];
    assign tgt_prod = PROD_W'(in_item.btb_target) * PROD_W'(RECIP);
    assign rst_prod = PROD_W'(in_item.restart_pc) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_opcode_reg <= '0;
            branch_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_wr.index)
                CFG_HALT_OPCODE: halt_opcode_reg <= cfg_wr.data[3:0];
                CFG_BRANCH_MASK: branch_mask_reg <= cfg_wr.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg   <= in_item;
        s1_tgt_q_reg  <= PC_OUT_W'(tgt_prod >> SHIFT);
        s1_rst_q_reg  <= PC_OUT_W'(rst_prod >> SHIFT);
        s1_branch_reg <= branch_mask_reg[opc];
        s1_halt_reg   <= (opc == halt_opcode_reg);
        s2_entry_reg  <= s2_entry_next;
    end

    always_comb
    begin
        tgt_qm  = MUL_W'(s1_tgt_q_reg) * MUL_W'(MOD_M);
        rst_qm  = MUL_W'(s1_rst_q_reg) * MUL_W'(MOD_M);
        tgt_rem = MUL_W'(s1_item_reg.btb_target) - tgt_qm;
        rst_rem = MUL_W'(s1_item_reg.restart_pc) - rst_qm;

        s2_entry_next.kind         = s1_item_reg.kind;
        s2_entry_next.queue_full   = s1_item_reg.queue_full;
        s2_entry_next.mispredicted = s1_item_reg.mispredicted;
        s2_entry_next.is_branch    = s1_branch_reg;
        s2_entry_next.is_halt      = s1_halt_reg;
        s2_entry_next.opcode       = s1_item_reg.instr_word[OPC_HI:OPC_LO];
        s2_entry_next.dest_reg     = s1_item_reg.instr_word[DEST_HI:DEST_LO];
        s2_entry_next.src_a        = s1_item_reg.instr_word[23:20];
        s2_entry_next.src_b        = s1_item_reg.instr_word[19:16];
        s2_entry_next.immediate    = s1_item_reg.instr_word[IMM_HI:0];
        s2_entry_next.btb_target   = s1_item_reg.btb_target;
        s2_entry_next.target_pc    = {(ADDR_W - PC_OUT_W)'(0), tgt_rem[PC_OUT_W-1:0]};
        s2_entry_next.restart_pc   = {(ADDR_W - PC_OUT_W)'(0), rst_rem[PC_OUT_W-1:0]};
    end

    assign out_valid = s2_valid_reg;
    assign out_entry = s2_entry_reg;

endmodule

// File: hw/rtl/sfs_back.sv
// Back part: owns the fetch state, carries out each decoded transaction and builds results.
// Depends on sfs_pkg; reads the middle queue and writes the result queue.
module sfs_back #(
    parameter int MEM_DEPTH = 1024,
    parameter int TAG_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   entry_valid,
    input  sfs_pkg::fetch_entry_t  entry,
    output logic                   entry_take,
    input  logic                   res_full,
    output logic                   res_push,
    output sfs_pkg::fetch_result_t res
);

    import sfs_pkg::*;

    localparam int PC_W = $clog2(MEM_DEPTH);

    logic [PC_W-1:0]     fetch_pc_reg, fetch_pc_next;
    logic                halt_seen_reg, halt_seen_next;
    logic                speculating_reg, speculating_next;
    logic [TAG_BITS-1:0] tag_counter_reg, tag_counter_next;

    logic [PC_W:0]                  pc_inc;
    logic [PC_W-1:0]                fall_pc;
    logic                           fetch_ok;
    logic [PC_W+PC_OUT_W-1:0]       npc_wide;
    logic [PC_W+PC_OUT_W-1:0]       fall_wide;
    logic [TAG_BITS+TAG_OUT_W-1:0]  tag_wide;

    assign entry_take = entry_valid && !res_full;
    assign pc_inc     = {1'b0, fetch_pc_reg} + 1'b1;
    assign fall_pc    = (pc_inc == (PC_W + 1)'(MEM_DEPTH)) ? '0 : pc_inc[PC_W-1:0];
    assign fetch_ok   = !entry.kind && !halt_seen_reg && !entry.queue_full
                        && !(entry.is_branch && speculating_reg);
    assign res_push   = entry_take && fetch_ok;

    always_comb
    begin
        fetch_pc_next    = fetch_pc_reg;
        halt_seen_next   = halt_seen_reg;
        speculating_next = speculating_reg;
        tag_counter_next = tag_counter_reg;
        if (entry_take)
        begin
            if (entry.kind)
            begin
                speculating_next = 1'b0;
                if (entry.mispredicted)
                begin
                    fetch_pc_next = entry.restart_pc[PC_W-1:0];
                end
            end
            else if (fetch_ok)
            begin
                tag_counter_next = tag_counter_reg + 1'b1;
                if (entry.is_halt)
                begin
                    halt_seen_next = 1'b1;
                end
                if (entry.is_branch)
                begin
                    speculating_next = 1'b1;
                    fetch_pc_next    = entry.target_pc[PC_W-1:0];
                end
                else
                begin
                    fetch_pc_next = fall_pc;
                end
            end
        end
    end

    always_comb
    begin
        npc_wide  = {PC_OUT_W'(0), fetch_pc_next};
        fall_wide = {PC_OUT_W'(0), fall_pc};
        tag_wide  = {TAG_OUT_W'(0), tag_counter_reg};

        res.opcode           = entry.opcode;
        res.dest_reg         = entry.dest_reg;
        res.src_a            = entry.src_a;
        res.src_b            = entry.src_b;
        res.immediate        = entry.immediate;
        res.tag              = tag_wide[TAG_OUT_W-1:0];
        res.speculative      = speculating_reg;
        res.predicted_target = entry.is_branch ? entry.btb_target : '0;
        res.fallthrough_pc   = entry.is_branch ? fall_wide[PC_OUT_W-1:0] : '0;
        res.next_pc          = npc_wide[PC_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_pc_reg    <= '0;
            halt_seen_reg   <= 1'b0;
            speculating_reg <= 1'b0;
            tag_counter_reg <= '0;
        end
        else
        begin
            fetch_pc_reg    <= fetch_pc_next;
            halt_seen_reg   <= halt_seen_next;
            speculating_reg <= speculating_next;
            tag_counter_reg <= tag_counter_next;
        end
    end

endmodule

// File: hw/rtl/speculative_fetch_stage.sv
// Top level of the speculative fetch stage: front part, middle queue, back part, result queue.
// Depends on sfs_pkg, sfs_queue, sfs_front, sfs_back and speculative_fetch_stage_assert.svh.
//
// Channel   Handshake               Payload
// item      push / full             item (fetch_item_t)
// result    pop / empty             result (fetch_result_t)
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// While full is low, one transaction is accepted per cycle; the back part's state update sets it.
// A result passes the front part's s1 and s2 registers, the middle queue and the result queue.
// Reset clears the fetch state, the configuration and both queues; cfg_ready is always high.
// Full rises when four transactions sit in the front part and the middle queue together.
// The back part stalls only when the two-entry result queue is full.
`include "speculative_fetch_stage_assert.svh"

module speculative_fetch_stage #(
    parameter int MEM_DEPTH = 1024,
    parameter int TAG_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  sfs_pkg::fetch_item_t              item,
    output logic                              empty,
    input  logic                              pop,
    output sfs_pkg::fetch_result_t            result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import sfs_pkg::*;

    localparam int CRED_W = $clog2(MID_DEPTH + 1);

    logic          in_take;
    cfg_write_t    cfg_wr;
    logic          mid_push;
    fetch_entry_t  mid_wr_entry;
    fetch_entry_t  mid_rd_entry;
    logic          mid_empty;
    logic          mid_full;
    logic          mid_pop;
    logic          res_push;
    logic          res_full;
    fetch_result_t res_wr;
    logic [CRED_W-1:0] inflight_reg, inflight_next;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;
    assign full         = (inflight_reg == CRED_W'(MID_DEPTH));
    assign in_take      = push && !full;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !mid_pop)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (mid_pop && !in_take)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    sfs_front #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .in_item   (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wr    (cfg_wr),
        .out_valid (mid_push),
        .out_entry (mid_wr_entry)
    );

    sfs_queue #(
        .WIDTH ($bits(fetch_entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr_entry),
        .pop     (mid_pop),
        .rd_data (mid_rd_entry),
        .empty   (mid_empty),
        .full    (mid_full)
    );

    sfs_back #(
        .MEM_DEPTH (MEM_DEPTH),
        .TAG_BITS  (TAG_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (!mid_empty),
        .entry       (mid_rd_entry),
        .entry_take  (mid_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_wr)
    );

    sfs_queue #(
        .WIDTH ($bits(fetch_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty),
        .full    (res_full)
    );

    `SFS_ASSERT_NEVER(a_credit_bound, clk, rst_n, inflight_reg > CRED_W'(MID_DEPTH))
    `SFS_ASSERT_NEVER(a_mid_no_overflow, clk, rst_n, mid_push && mid_full)
    `SFS_ASSERT_NEXT(a_credit_count, clk, rst_n, in_take && !mid_pop, inflight_reg == $past(inflight_reg) + 1'b1)
    `SFS_ASSERT_NEVER(a_credit_covers_queue, clk, rst_n, inflight_reg < CRED_W'(mid_push) + CRED_W'(!mid_empty))

endmodule

// File: bench/fetch_stage_checker.sv
// Checker of the speculative fetch stage: decodes every accepted fetch transaction
// into the result it must produce and compares the results that are popped.
// Depends on sfs_pkg; instantiated by tb_speculative_fetch_stage.
`timescale 1ns / 1ps

module fetch_stage_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  sfs_pkg::fetch_item_t           item,
    input  logic                           empty,
    input  logic                           pop,
    input  sfs_pkg::fetch_result_t         result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    import sfs_pkg::*;

    pc_t         fetch_pc;
    logic        halted;
    logic        speculating;
    logic [15:0] tag_count;
    nibble_t     halt_op;
    logic [15:0] branch_mask;

    fetch_result_t decoded_queue[$];
    int mismatch_count = 0;
    int waiting_count = 0;

    assign mismatches = mismatch_count;
    assign outstanding = waiting_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic decode_fetch(input fetch_item_t it);
        fetch_result_t r;
        nibble_t       op;
        logic          is_branch;
        op = it.instr_word[OPC_HI:OPC_LO];
        is_branch = branch_mask[op];
        if (it.kind)
        begin
            speculating = 1'b0;
            if (it.mispredicted)
            begin
                fetch_pc = it.restart_pc;
            end
        end
        else if (!halted && !it.queue_full && !(is_branch && speculating))
        begin
            r.opcode = op;
            r.dest_reg = it.instr_word[DEST_HI:DEST_LO];
            r.src_a = it.instr_word[23:20];
            r.src_b = it.instr_word[19:16];
            r.immediate = it.instr_word[IMM_HI:0];
            r.tag = tag_count;
            r.speculative = speculating;
            tag_count = tag_count + 16'd1;
            if (op == halt_op)
            begin
                halted = 1'b1;
            end
            if (is_branch)
            begin
                r.predicted_target = it.btb_target;
                r.fallthrough_pc = fetch_pc + 10'd1;
                speculating = 1'b1;
                fetch_pc = it.btb_target;
            end
            else
            begin
                r.predicted_target = '0;
                r.fallthrough_pc = '0;
                fetch_pc = fetch_pc + 10'd1;
            end
            r.next_pc = fetch_pc;
            decoded_queue.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        fetch_result_t want;
        if (!rst_n)
        begin
            fetch_pc = '0;
            halted = 1'b0;
            speculating = 1'b0;
            tag_count = '0;
            halt_op = '0;
            branch_mask = '0;
            decoded_queue.delete();
            waiting_count <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (decoded_queue.size() == 0)
                begin
                    report_mismatch("result with no transaction waiting, tag",
                                    32'(result.tag), '0);
                end
                else
                begin
                    want = decoded_queue.pop_front();
                    check_field("opcode", 32'(result.opcode), 32'(want.opcode));
                    check_field("dest_reg", 32'(result.dest_reg), 32'(want.dest_reg));
                    check_field("src_a", 32'(result.src_a), 32'(want.src_a));
                    check_field("src_b", 32'(result.src_b), 32'(want.src_b));
                    check_field("immediate", 32'(result.immediate), 32'(want.immediate));
                    check_field("tag", 32'(result.tag), 32'(want.tag));
                    check_field("speculative", 32'(result.speculative),
                                32'(want.speculative));
                    check_field("predicted_target", 32'(result.predicted_target),
                                32'(want.predicted_target));
                    check_field("fallthrough_pc", 32'(result.fallthrough_pc),
                                32'(want.fallthrough_pc));
                    check_field("next_pc", 32'(result.next_pc), 32'(want.next_pc));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HALT_OPCODE)
                begin
                    halt_op = cfg_data[3:0];
                end
                else if (cfg_index == CFG_BRANCH_MASK)
                begin
                    branch_mask = cfg_data;
                end
            end
            if (push && !full)
            begin
                decode_fetch(item);
            end
            waiting_count <= decoded_queue.size();
        end
    end

endmodule

// File: bench/tb_speculative_fetch_stage.sv
// Top of the speculative fetch stage testbench: clock, reset, fetch and resolve stimulus,
// register writes, result-side stalls, watchdog and verdict.
// Depends on sfs_pkg, speculative_fetch_stage and fetch_stage_checker.
`timescale 1ns / 1ps

module tb_speculative_fetch_stage;
    import sfs_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 260;
    localparam int PHASES       = 5;

    localparam nibble_t     HALT_SET[PHASES] = '{4'd15, 4'd0, 4'd15, 4'd9, 4'd0};
    localparam logic [15:0] MASK_SET[PHASES] =
        '{16'h00F0, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h0000};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    fetch_item_t           item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    fetch_result_t         result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int      mismatches;
    int      outstanding;
    logic    calm = 1'b0;
    int      pop_hold = 0;
    int      quiet_cycles = 0;
    nibble_t halt_code = '0;

    speculative_fetch_stage u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fetch_stage_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b0;
        #1 clk = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            pop <= rst_n;
        end
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                pop_hold <= int'($urandom_range(1, 7));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic fetch_item_t make_fetch(input logic [31:0] word, input pc_t target,
                                               input logic no_room);
        fetch_item_t it;
        it.kind = 1'b0;
        it.instr_word = word;
        it.btb_target = target;
        it.queue_full = no_room;
        it.mispredicted = 1'($urandom_range(0, 1));
        it.restart_pc = pc_t'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic fetch_item_t make_resolve(input logic redirect, input pc_t restart);
        fetch_item_t it;
        it.kind = 1'b1;
        it.instr_word = $urandom();
        it.btb_target = pc_t'($urandom_range(0, 1023));
        it.queue_full = 1'($urandom_range(0, 1));
        it.mispredicted = redirect;
        it.restart_pc = restart;
        return it;
    endfunction

    function automatic fetch_item_t random_item(input nibble_t stop_code);
        logic [31:0] word;
        logic        no_room;
        if ($urandom_range(0, 99) < 20)
        begin
            return make_resolve(1'($urandom_range(0, 1)), pc_t'($urandom_range(0, 1023)));
        end
        word = $urandom();
        no_room = ($urandom_range(0, 9) == 0);
        while (!no_room && word[OPC_HI:OPC_LO] == stop_code)
        begin
            word[OPC_HI:OPC_LO] = nibble_t'($urandom_range(0, 15));
        end
        return make_fetch(word, pc_t'($urandom_range(0, 1023)), no_room);
    endfunction

    task automatic send(input fetch_item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        repeat (RANDOM_ITEMS) send(random_item(halt_code));
    endtask

    task automatic drain();
        if (push)
        begin
            push <= 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_config(input nibble_t stop_code, input logic [15:0] mask);
        write_reg(CFG_HALT_OPCODE, {12'd0, stop_code});
        write_reg(CFG_BRANCH_MASK, mask);
        cfg_valid <= 1'b0;
        halt_code = stop_code;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_random();
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_config(HALT_SET[p], MASK_SET[p]);
            if (p == 0)
            begin
                send(make_resolve(1'b1, 10'h000));
                send(make_fetch(32'h0000_0000, 10'h000, 1'b0));
                send(make_fetch(32'hEFFF_FFFF, 10'h3FF, 1'b0));
                send(make_fetch(32'hFFFF_FFFF, 10'h3FF, 1'b1));
                send(make_resolve(1'b1, 10'h3FF));
                send(make_fetch(32'h1234_5678, 10'h155, 1'b0));
                send(make_resolve(1'b1, 10'h3FE));
                send(make_fetch(32'h4A5A_5A5A, 10'h3FF, 1'b0));
                send(make_fetch(32'h2000_FFFF, 10'h000, 1'b0));
                send(make_fetch(32'h7FFF_0000, 10'h2AA, 1'b0));
                send(make_resolve(1'b0, 10'h3FF));
                send(make_fetch(32'h5000_0001, 10'h000, 1'b0));
                send(make_fetch(32'h6000_0000, 10'h3FF, 1'b1));
                send(make_resolve(1'b1, 10'h2AA));
                send(make_fetch(32'h8C3C_3C3C, 10'h3FF, 1'b0));
            end
            if (p == PHASES - 1)
            begin
                calm <= 1'b1;
            end
            send_random();
        end
        drain();
        set_config(4'd6, 16'h00C0);
        send(make_resolve(1'b0, 10'h000));
        send(make_fetch(32'h7123_4567, 10'h100, 1'b0));
        send(make_fetch(32'h6ABC_DEF0, 10'h200, 1'b0));
        send(make_resolve(1'b0, 10'h000));
        send(make_fetch(32'h6FFF_FFFF, 10'h3FF, 1'b0));
        send(make_fetch(32'h1000_0000, 10'h000, 1'b0));
        send(make_resolve(1'b1, 10'h005));
        send(make_fetch(32'h2000_0000, 10'h000, 1'b0));
        drain();
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
